/* hw/rtl/thermal_counts_to_celsius_unit_assert.svh */
// Assertion macros for the counts-to-Celsius unit.
// Used by thermal_counts_to_celsius_unit.sv; expects clk and arst_n in scope.
`ifndef THERMAL_COUNTS_TO_CELSIUS_UNIT_ASSERT_SVH
`define THERMAL_COUNTS_TO_CELSIUS_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TCTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define TCTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/tctc_pkg.sv */
// Shared types and constants for the counts-to-Celsius unit.
// No dependencies.
package tctc_pkg;

	localparam int COUNT_BITS = 16;

	// (counts << 16) - J0 needs this many bits, signed
	localparam int DIFF_W = ((COUNT_BITS + 16 > 32) ? COUNT_BITS + 16 : 32) + 2;
	localparam int MAG_W  = DIFF_W - 1;

	// quotient bits of the three divider pipelines
	localparam int Q1 = 31;
	localparam int Q2 = 47;
	localparam int Q3 = 40;

	localparam int LOG_FRAC = 28;
	localparam int SQ_N     = LOG_FRAC;

	localparam logic [27:0] LN2_Q28      = 28'd186065280;
	localparam logic [30:0] SIG_MAX      = 31'h7FFF_FFFF;
	localparam logic [62:0] ARG_MAX      = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [31:0] T_MAX = 32'sd200000;
	localparam logic signed [31:0] ZERO_C_CENTI = 32'sd27315;

	typedef enum logic [2:0] {
		REG_COUNT_OFFSET      = 3'd0,
		REG_COUNT_GAIN        = 3'd1,
		REG_TRANSMISSION_GAIN = 3'd2,
		REG_AMBIENT_RADIANCE  = 3'd3,
		REG_PLANCK_R          = 3'd4,
		REG_PLANCK_B          = 3'd5,
		REG_PLANCK_F          = 3'd6
	} cfg_reg_t;

endpackage

/* hw/rtl/thermal_counts_to_celsius_unit.sv */
// Radiometric counts to object temperature, fully pipelined.
// Depends on tctc_pkg and thermal_counts_to_celsius_unit_assert.svh.
//
// Usage:
//  Input: one pixel count per transfer, taken at a clock edge with start high and
//  busy low. busy stays low; a new count may be sent every cycle.
//  Output: done is high for one cycle with temperature_centi_c and invalid;
//  the receiver takes it at that edge and cannot hold it off.
//  Throughput: one result per cycle. The depth is set by three restoring
//  divider pipelines (one quotient bit per stage: 31, 47 and 40 stages) and
//  the 28 squaring stages of the log2 unit.
//  Configuration: cfg_we writes cfg_wdata into register cfg_index at the edge;
//  write only while no item is in flight.
//  Reset: arst_n clears the valid bits of every stage and loads the register
//  defaults; items in flight are dropped.
//  invalid is set when the denominator is zero, when the log argument or the log
//  itself is not positive, or when ln rounds to zero; the temperature then reads 0.
module thermal_counts_to_celsius_unit
	import tctc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [COUNT_BITS-1:0]   sensor_counts,
	output logic                    done,
	output logic signed [18:0]      temperature_centi_c,
	output logic                    invalid,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [47:0]             cfg_wdata
);

	// ---------------- configuration registers
	logic [31:0] count_offset_q;
	logic [31:0] count_gain_q;
	logic [31:0] transmission_gain_q;
	logic [31:0] ambient_radiance_q;
	logic [47:0] planck_r_q;
	logic [31:0] planck_b_q;
	logic [31:0] planck_f_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_offset_q      <= 32'd0;
			count_gain_q        <= 32'd65536;
			transmission_gain_q <= 32'd16777216;
			ambient_radiance_q  <= 32'd0;
			planck_r_q          <= 48'd65536;
			planck_b_q          <= 32'd65536;
			planck_f_q          <= 32'd16777216;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COUNT_OFFSET:      count_offset_q      <= cfg_wdata[31:0];
				REG_COUNT_GAIN:        count_gain_q        <= cfg_wdata[31:0];
				REG_TRANSMISSION_GAIN: transmission_gain_q <= cfg_wdata[31:0];
				REG_AMBIENT_RADIANCE:  ambient_radiance_q  <= cfg_wdata[31:0];
				REG_PLANCK_R:          planck_r_q          <= cfg_wdata;
				REG_PLANCK_B:          planck_b_q          <= cfg_wdata[31:0];
				REG_PLANCK_F:          planck_f_q          <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic in_xfer;
	assign in_xfer = start && !busy;

	// ---------------- s1: offset removal
	logic signed [DIFF_W-1:0] diff;
	logic                     vld_s1;
	logic                     neg_s1;
	logic [MAG_W-1:0]         mag_s1;

	assign diff = $signed({{(DIFF_W-COUNT_BITS-16){1'b0}}, sensor_counts, 16'b0})
		- $signed({{(DIFF_W-32){count_offset_q[31]}}, count_offset_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= in_xfer;
	end

	always_ff @(posedge clk) begin
		neg_s1 <= diff[DIFF_W-1];
		mag_s1 <= diff[DIFF_W-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];
	end

	// ---------------- s2: divider 1, sig = (mag << 16) / gain
	logic [31:0] gain_eff;
	logic [MAG_W-1:0] d1_top;
	logic d1_ovf;
	assign gain_eff = (count_gain_q == 32'd0) ? 32'd1 : count_gain_q;
	assign d1_top   = mag_s1 >> 15;
	assign d1_ovf   = d1_top >= {{(MAG_W-32){1'b0}}, gain_eff};

	logic          d1_vld_s [0:Q1];
	logic          d1_ovf_s [0:Q1];
	logic          d1_neg_s [0:Q1];
	logic [31:0]   d1_rem_s [0:Q1];
	logic [Q1-1:0] d1_quo_s [0:Q1];
	logic [Q1-1:0] d1_nlo_s [0:Q1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) d1_vld_s[0] <= 1'b0;
		else d1_vld_s[0] <= vld_s1;
	end

	always_ff @(posedge clk) begin
		d1_ovf_s[0] <= d1_ovf;
		d1_neg_s[0] <= neg_s1;
		d1_rem_s[0] <= d1_ovf ? 32'd0 : 32'(d1_top);
		d1_quo_s[0] <= '0;
		d1_nlo_s[0] <= {mag_s1[14:0], 16'b0};
	end

	for (genvar i = 0; i < Q1; i++) begin : g_d1
		logic [32:0] trial;
		logic        ge;
		logic [31:0] nrem;
		assign trial = {d1_rem_s[i], d1_nlo_s[i][Q1-1]};
		assign ge    = trial >= {1'b0, gain_eff};
		assign nrem  = ge ? 32'(trial - {1'b0, gain_eff}) : trial[31:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) d1_vld_s[i+1] <= 1'b0;
			else d1_vld_s[i+1] <= d1_vld_s[i];
		end

		always_ff @(posedge clk) begin
			d1_ovf_s[i+1] <= d1_ovf_s[i];
			d1_neg_s[i+1] <= d1_neg_s[i];
			d1_rem_s[i+1] <= nrem;
			d1_quo_s[i+1] <= {d1_quo_s[i][Q1-2:0], ge};
			d1_nlo_s[i+1] <= d1_nlo_s[i] << 1;
		end
	end

	// ---------------- s3: transmission gain
	logic [30:0] sig;
	logic [62:0] prod_full;
	logic        vld_s3;
	logic        neg_s3;
	logic [38:0] prod_s3;
	assign sig       = d1_ovf_s[Q1] ? SIG_MAX : d1_quo_s[Q1];
	assign prod_full = sig * transmission_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= d1_vld_s[Q1];
	end

	always_ff @(posedge clk) begin
		neg_s3  <= d1_neg_s[Q1];
		prod_s3 <= prod_full[62:24];
	end

	// ---------------- s4: subtract ambient radiance
	logic signed [40:0] sprod;
	logic               vld_s4;
	logic signed [40:0] den_s4;
	assign sprod = neg_s3 ? -$signed({2'b0, prod_s3}) : $signed({2'b0, prod_s3});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		den_s4 <= sprod - $signed({{9{ambient_radiance_q[31]}}, ambient_radiance_q});
	end

	// ---------------- s5: magnitude of the denominator
	logic        vld_s5;
	logic        bad_s5;
	logic        pos_s5;
	logic [39:0] d_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		bad_s5 <= den_s4 == 41'sd0;
		pos_s5 <= !den_s4[40] && (den_s4 != 41'sd0);
		d_s5   <= den_s4[40] ? 40'(-den_s4) : den_s4[39:0];
	end

	// ---------------- s6: divider 2, q24 = (R << 24) / d
	logic [39:0] d2_top;
	logic        d2_ovf;
	assign d2_top = {15'b0, planck_r_q[47:23]};
	assign d2_ovf = d2_top >= d_s5;

	logic          d2_vld_s [0:Q2];
	logic          d2_ovf_s [0:Q2];
	logic          d2_bad_s [0:Q2];
	logic          d2_pos_s [0:Q2];
	logic [39:0]   d2_div_s [0:Q2];
	logic [39:0]   d2_rem_s [0:Q2];
	logic [Q2-1:0] d2_quo_s [0:Q2];
	logic [Q2-1:0] d2_nlo_s [0:Q2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) d2_vld_s[0] <= 1'b0;
		else d2_vld_s[0] <= vld_s5;
	end

	always_ff @(posedge clk) begin
		d2_ovf_s[0] <= d2_ovf;
		d2_bad_s[0] <= bad_s5;
		d2_pos_s[0] <= pos_s5;
		d2_div_s[0] <= d_s5;
		d2_rem_s[0] <= d2_ovf ? 40'd0 : d2_top;
		d2_quo_s[0] <= '0;
		d2_nlo_s[0] <= {planck_r_q[22:0], 24'b0};
	end

	for (genvar i = 0; i < Q2; i++) begin : g_d2
		logic [40:0] trial;
		logic        ge;
		logic [39:0] nrem;
		assign trial = {d2_rem_s[i], d2_nlo_s[i][Q2-1]};
		assign ge    = trial >= {1'b0, d2_div_s[i]};
		assign nrem  = ge ? 40'(trial - {1'b0, d2_div_s[i]}) : trial[39:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) d2_vld_s[i+1] <= 1'b0;
			else d2_vld_s[i+1] <= d2_vld_s[i];
		end

		always_ff @(posedge clk) begin
			d2_ovf_s[i+1] <= d2_ovf_s[i];
			d2_bad_s[i+1] <= d2_bad_s[i];
			d2_pos_s[i+1] <= d2_pos_s[i];
			d2_div_s[i+1] <= d2_div_s[i];
			d2_rem_s[i+1] <= nrem;
			d2_quo_s[i+1] <= {d2_quo_s[i][Q2-2:0], ge};
			d2_nlo_s[i+1] <= d2_nlo_s[i] << 1;
		end
	end

	// ---------------- s7: log argument
	logic [Q2-1:0] q24;
	logic [62:0]   arg_sum;
	logic [62:0]   arg_nxt;
	logic          bad_nxt;
	logic          vld_s7;
	logic          bad_s7;
	logic [62:0]   arg_s7;
	assign q24     = d2_quo_s[Q2];
	assign arg_sum = {16'b0, q24} + {31'b0, planck_f_q};

	always_comb begin
		if (d2_pos_s[Q2]) begin
			bad_nxt = d2_bad_s[Q2];
			arg_nxt = d2_ovf_s[Q2] ? ARG_MAX : arg_sum;
		end else begin
			// negative denominator: F - q must stay positive
			bad_nxt = d2_bad_s[Q2] || d2_ovf_s[Q2] || (q24 >= {15'b0, planck_f_q});
			arg_nxt = {31'b0, planck_f_q - q24[31:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else vld_s7 <= d2_vld_s[Q2];
	end

	always_ff @(posedge clk) begin
		bad_s7 <= bad_nxt;
		arg_s7 <= arg_nxt;
	end

	// ---------------- s8: leading one per byte
	logic [63:0] a64;
	logic [7:0]  nz_nxt;
	logic [2:0]  pos_nxt [0:7];
	logic        vld_s8;
	logic        bad_s8;
	logic [62:0] arg_s8;
	logic [7:0]  nz_s8;
	logic [2:0]  pos_s8 [0:7];
	assign a64 = {1'b0, arg_s7};

	always_comb begin
		for (int c = 0; c < 8; c++) begin
			nz_nxt[c]  = |a64[8*c +: 8];
			pos_nxt[c] = 3'd0;
			for (int j = 0; j < 8; j++) begin
				if (a64[8*c + j]) pos_nxt[c] = 3'(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		bad_s8 <= bad_s7;
		arg_s8 <= arg_s7;
		nz_s8  <= nz_nxt;
		pos_s8 <= pos_nxt;
	end

	// ---------------- s9: leading one of the word
	logic [5:0]  p_nxt;
	logic        vld_s9;
	logic        bad_s9;
	logic [62:0] arg_s9;
	logic [5:0]  p_s9;

	always_comb begin
		p_nxt = 6'd0;
		for (int c = 0; c < 8; c++) begin
			if (nz_s8[c]) p_nxt = {3'(c), pos_s8[c]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s9 <= 1'b0;
		else vld_s9 <= vld_s8;
	end

	always_ff @(posedge clk) begin
		bad_s9 <= bad_s8 || (nz_s8 == 8'd0);
		arg_s9 <= arg_s8;
		p_s9   <= p_nxt;
	end

	// ---------------- s10: normalize to [2^30, 2^31), then squaring steps
	logic [92:0] norm;
	assign norm = {arg_s9, 30'b0} >> p_s9;

	logic               sq_vld_s  [0:SQ_N];
	logic               sq_bad_s  [0:SQ_N];
	logic signed [6:0]  sq_ip_s   [0:SQ_N];
	logic [30:0]        sq_x_s    [0:SQ_N];
	logic [SQ_N-1:0]    sq_frac_s [0:SQ_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_vld_s[0] <= 1'b0;
		else sq_vld_s[0] <= vld_s9;
	end

	always_ff @(posedge clk) begin
		sq_bad_s[0]  <= bad_s9;
		sq_ip_s[0]   <= $signed({1'b0, p_s9}) - 7'sd24;
		sq_x_s[0]    <= norm[30:0];
		sq_frac_s[0] <= '0;
	end

	for (genvar i = 0; i < SQ_N; i++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] t;
		assign sq = sq_x_s[i] * sq_x_s[i];
		assign t  = sq[61:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_vld_s[i+1] <= 1'b0;
			else sq_vld_s[i+1] <= sq_vld_s[i];
		end

		always_ff @(posedge clk) begin
			sq_bad_s[i+1]  <= sq_bad_s[i];
			sq_ip_s[i+1]   <= sq_ip_s[i];
			sq_x_s[i+1]    <= t[31] ? t[31:1] : t[30:0];
			sq_frac_s[i+1] <= {sq_frac_s[i][SQ_N-2:0], t[31]};
		end
	end

	// ---------------- s12: assemble log2, reject non-positive
	logic signed [6:0] ip_f;
	logic [SQ_N-1:0]   frac_f;
	logic              vld_s12;
	logic              bad_s12;
	logic [33:0]       l2_s12;
	assign ip_f   = sq_ip_s[SQ_N];
	assign frac_f = sq_frac_s[SQ_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s12 <= 1'b0;
		else vld_s12 <= sq_vld_s[SQ_N];
	end

	always_ff @(posedge clk) begin
		bad_s12 <= sq_bad_s[SQ_N] || ip_f[6] || ((ip_f == 7'sd0) && (frac_f == '0));
		l2_s12  <= {ip_f[5:0], frac_f};
	end

	// ---------------- s13: ln = log2 * ln2
	logic [61:0] ln_full;
	logic        vld_s13;
	logic        bad_s13;
	logic [33:0] lnv_s13;
	assign ln_full = l2_s12 * LN2_Q28;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s13 <= 1'b0;
		else vld_s13 <= vld_s12;
	end

	always_ff @(posedge clk) begin
		bad_s13 <= bad_s12;
		lnv_s13 <= ln_full[61:28];
	end

	// ---------------- s14: divider 3, tk = (B << 28) / ln
	logic [33:0] d3_top;
	logic        d3_ovf;
	assign d3_top = {14'b0, planck_b_q[31:12]};
	assign d3_ovf = d3_top >= lnv_s13;

	logic          d3_vld_s [0:Q3];
	logic          d3_ovf_s [0:Q3];
	logic          d3_bad_s [0:Q3];
	logic [33:0]   d3_div_s [0:Q3];
	logic [33:0]   d3_rem_s [0:Q3];
	logic [Q3-1:0] d3_quo_s [0:Q3];
	logic [Q3-1:0] d3_nlo_s [0:Q3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) d3_vld_s[0] <= 1'b0;
		else d3_vld_s[0] <= vld_s13;
	end

	always_ff @(posedge clk) begin
		d3_ovf_s[0] <= d3_ovf;
		d3_bad_s[0] <= bad_s13 || (lnv_s13 == 34'd0);
		d3_div_s[0] <= lnv_s13;
		d3_rem_s[0] <= d3_ovf ? 34'd0 : d3_top;
		d3_quo_s[0] <= '0;
		d3_nlo_s[0] <= {planck_b_q[11:0], 28'b0};
	end

	for (genvar i = 0; i < Q3; i++) begin : g_d3
		logic [34:0] trial;
		logic        ge;
		logic [33:0] nrem;
		assign trial = {d3_rem_s[i], d3_nlo_s[i][Q3-1]};
		assign ge    = trial >= {1'b0, d3_div_s[i]};
		assign nrem  = ge ? 34'(trial - {1'b0, d3_div_s[i]}) : trial[33:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) d3_vld_s[i+1] <= 1'b0;
			else d3_vld_s[i+1] <= d3_vld_s[i];
		end

		always_ff @(posedge clk) begin
			d3_ovf_s[i+1] <= d3_ovf_s[i];
			d3_bad_s[i+1] <= d3_bad_s[i];
			d3_div_s[i+1] <= d3_div_s[i];
			d3_rem_s[i+1] <= nrem;
			d3_quo_s[i+1] <= {d3_quo_s[i][Q3-2:0], ge};
			d3_nlo_s[i+1] <= d3_nlo_s[i] << 1;
		end
	end

	// ---------------- s15: kelvin to centi-kelvin, rounded
	logic [46:0] t100;
	logic        vld_s15;
	logic        bad_s15;
	logic        cap_s15;
	logic [30:0] ck_s15;
	assign t100 = {7'b0, d3_quo_s[Q3]} * 47'd100 + 47'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s15 <= 1'b0;
		else vld_s15 <= d3_vld_s[Q3];
	end

	always_ff @(posedge clk) begin
		bad_s15 <= d3_bad_s[Q3];
		cap_s15 <= d3_ovf_s[Q3];
		ck_s15  <= t100[46:16];
	end

	// ---------------- output register: Celsius, hot clamp
	logic signed [31:0] centi;
	logic signed [31:0] centi_sat;
	assign centi     = $signed({1'b0, ck_s15}) - ZERO_C_CENTI;
	assign centi_sat = (cap_s15 || (centi > T_MAX)) ? T_MAX : centi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_s15;
	end

	always_ff @(posedge clk) begin
		invalid             <= bad_s15;
		temperature_centi_c <= bad_s15 ? 19'sd0 : centi_sat[18:0];
	end

	// ---------------- checks
`include "thermal_counts_to_celsius_unit_assert.svh"

	`TCTC_ASSERT_NEXT(a_in_enters, in_xfer, vld_s1, "input transfer did not enter the pipeline")
	`TCTC_ASSERT_NOW(a_inv_zero, done && invalid, temperature_centi_c == 19'sd0, "invalid result with nonzero temperature")
	`TCTC_ASSERT_NOW(a_temp_range, done && !invalid, (temperature_centi_c >= -19'sd27315) && (temperature_centi_c <= 19'sd200000), "temperature out of range")
	`TCTC_ASSERT_NOW(a_log_norm, sq_vld_s[SQ_N] && !sq_bad_s[SQ_N], sq_x_s[SQ_N][30], "log mantissa lost normalization")
	`TCTC_ASSERT_NOW(a_d2_rem, d2_vld_s[Q2] && !d2_ovf_s[Q2] && !d2_bad_s[Q2], d2_rem_s[Q2] < d2_div_s[Q2], "divider remainder not below divisor")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for thermal_counts_to_celsius_unit.
// Depends on tctc_pkg and the unit; a scoreboard class predicts each temperature.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tctc_pkg::*;

	typedef struct {
		logic signed [18:0] centi;
		logic               bad;
	} temp_result_t;

	class temp_scoreboard;
		longint          j0;
		longint unsigned j1, k1, r, b, f;
		longint          k2;
		temp_result_t    pending_q[$];
		int              errors;

		function new();
			j0 = 0; j1 = 65536; k1 = 16777216; k2 = 0;
			r = 65536; b = 65536; f = 16777216;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [47:0] val);
			case (idx)
				REG_COUNT_OFFSET:      j0 = longint'(signed'(val[31:0]));
				REG_COUNT_GAIN:        j1 = val[31:0];
				REG_TRANSMISSION_GAIN: k1 = val[31:0];
				REG_AMBIENT_RADIANCE:  k2 = longint'(signed'(val[31:0]));
				REG_PLANCK_R:          r = val;
				REG_PLANCK_B:          b = val[31:0];
				REG_PLANCK_F:          f = val[31:0];
				default: ;
			endcase
		endfunction

		// log2 of a positive Q.24 value in Q.28
		function longint log2_q28(longint unsigned a);
			int p;
			longint unsigned x, frac;
			p = 62;
			frac = 0;
			while (p > 0 && a[p] == 1'b0)
				p--;
			x = (p >= 30) ? (a >> (p - 30)) : (a << (30 - p));
			for (int i = 1; i <= LOG_FRAC; i++) begin
				x = (x * x) >> 30;
				if (x >= 64'd2147483648) begin
					x = x >> 1;
					frac |= 64'd1 << (LOG_FRAC - i);
				end
			end
			return (longint'(p) - 24) * 64'sd268435456 + longint'(frac);
		endfunction

		function temp_result_t celsius_of(logic [COUNT_BITS-1:0] cnt);
			temp_result_t res;
			longint diff, den, l2, centi;
			longint unsigned mag, gain, sig, prod, d, num, q16, rem, q24, arg, lnv, tk;
			bit neg;
			res.centi = '0;
			res.bad = 1'b1;
			diff = longint'({cnt, 16'h0}) - j0;
			neg = diff < 0;
			mag = neg ? longint'(-diff) : diff;
			gain = (j1 != 0) ? j1 : 64'd1;
			sig = (mag << 16) / gain;
			if (sig > 64'h7FFF_FFFF)
				sig = 64'h7FFF_FFFF;
			prod = (sig * k1) >> 24;
			den = (neg ? -longint'(prod) : longint'(prod)) - k2;
			if (den == 0)
				return res;
			d = (den < 0) ? longint'(-den) : den;
			num = r << 16;
			q16 = num / d;
			rem = num % d;
			if (q16 >= (64'd1 << 39))
				q24 = 64'h7FFF_FFFF_FFFF_FFFF;
			else
				q24 = (q16 << 8) + ((rem << 8) / d);
			if (den > 0) begin
				arg = q24 + f;
				if (arg > 64'h7FFF_FFFF_FFFF_FFFF)
					arg = 64'h7FFF_FFFF_FFFF_FFFF;
			end else begin
				if (q24 >= f)
					return res;
				arg = f - q24;
			end
			if (arg == 0)
				return res;
			l2 = log2_q28(arg);
			if (l2 <= 0)
				return res;
			lnv = (longint'(l2) * 64'd186065280) >> LOG_FRAC;
			if (lnv == 0)
				return res;
			tk = (b << LOG_FRAC) / lnv;
			if (tk >= (64'd1 << 40)) begin
				centi = 200000;
			end else begin
				centi = longint'((tk * 100 + 32768) >> 16) - 27315;
				if (centi > 200000)
					centi = 200000;
			end
			res.centi = centi[18:0];
			res.bad = 1'b0;
			return res;
		endfunction

		function void note_count(logic [COUNT_BITS-1:0] cnt);
			pending_q.push_back(celsius_of(cnt));
		endfunction

		function void check_temp(logic signed [18:0] centi, logic bad);
			temp_result_t exp_r;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result temp=%0d invalid=%0b", $time, centi, bad);
				errors++;
				return;
			end
			exp_r = pending_q.pop_front();
			if (centi !== exp_r.centi) begin
				$display("%0t: temperature expected %0d actual %0d", $time, exp_r.centi, centi);
				errors++;
			end
			if (bad !== exp_r.bad) begin
				$display("%0t: invalid expected %0b actual %0b", $time, exp_r.bad, bad);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [COUNT_BITS-1:0] sensor_counts;
	logic                  done;
	logic signed [18:0]    temperature_centi_c;
	logic                  invalid;
	logic                  cfg_we;
	logic [2:0]            cfg_index;
	logic [47:0]           cfg_wdata;

	temp_scoreboard sb;
	int  cycles;
	bit  quiet;

	thermal_counts_to_celsius_unit DUT (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// transfers in and out
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_count(sensor_counts);
		if (arst_n && done)
			sb.check_temp(temperature_centi_c, invalid);
	end

	task automatic send_count(logic [COUNT_BITS-1:0] c);
		start <= 1'b1;
		sensor_counts <= c;
		do @(posedge clk); while (busy);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_regs(logic [47:0] v[7]);
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_wdata <= v[i];
			sb.write_reg(cfg_reg_t'(i), v[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [COUNT_BITS-1:0] rand_count(logic [47:0] j0);
		logic [15:0] near;
		near = j0[31:16];
		case ($urandom_range(0, 3))
			0: return COUNT_BITS'(near + 16'($urandom_range(0, 8)) - 16'd4);
			1: return COUNT_BITS'($urandom_range(0, 255));
			default: return COUNT_BITS'($urandom);
		endcase
	endfunction

	initial begin
		logic [47:0] regs[7];
		logic [COUNT_BITS-1:0] directed[$];
		sb = new();
		quiet = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		sensor_counts = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: zero, small and large counts
		directed = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'h8000};
		foreach (directed[i])
			send_count(directed[i]);
		drain();

		// typical camera calibration
		regs = '{48'd0, 48'd65536, 48'd16777216, 48'd0,
			48'd400000 << 16, 48'd1400 << 16, 48'd16777216};
		load_regs(regs);
		directed = '{16'd0, 16'd1, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA,
			16'd10000, 16'd20000, 16'd3, 16'h00FF, 16'hFF00, 16'd100};
		foreach (directed[i])
			send_count(directed[i]);
		for (int n = 0; n < 200; n++)
			send_count(rand_count(regs[0]));
		drain();

		// offset and ambient term, negative denominators
		regs = '{48'(32'd12000 << 16), 48'd3 << 15, 48'd20000000, 48'(-32'sd5000 << 16),
			48'd9000 << 16, 48'd1500 << 16, 48'd20000000};
		load_regs(regs);
		for (int n = 0; n < 200; n++)
			send_count(rand_count(regs[0]));
		drain();

		// zero gain, max transmission, huge R
		regs = '{48'd0, 48'd0, 48'hFFFF_FFFF, 48'd0,
			48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF, 48'hFFFF_FFFF};
		load_regs(regs);
		send_count(16'd0);
		send_count(16'hFFFF);
		for (int n = 0; n < 150; n++)
			send_count(rand_count(regs[0]));
		drain();

		// max registers, minimum offset and ambient
		regs = '{48'h8000_0000, 48'hFFFF_FFFF, 48'hFFFF_FFFF, 48'h8000_0000,
			48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF, 48'hFFFF_FFFF};
		load_regs(regs);
		for (int n = 0; n < 150; n++)
			send_count(rand_count(regs[0]));
		drain();

		// zero B, F and R: absolute zero and invalid outcomes
		regs = '{48'h7FFF_FFFF, 48'd1, 48'd0, 48'h7FFF_FFFF, 48'd0, 48'd0, 48'd0};
		load_regs(regs);
		for (int n = 0; n < 100; n++)
			send_count(rand_count(regs[0]));
		drain();
		regs = '{48'd0, 48'd65536, 48'd16777216, 48'd0, 48'd1 << 16, 48'd0, 48'd1 << 24};
		load_regs(regs);
		for (int n = 0; n < 100; n++)
			send_count(rand_count(regs[0]));
		drain();

		// randomized calibrations, mostly near realistic scale
		for (int ph = 0; ph < 8; ph++) begin
			regs[0] = 48'(32'($urandom_range(0, 30000)) << 16);
			regs[1] = ($urandom_range(0, 3) == 0) ? 48'($urandom) : 48'($urandom_range(1, 262144));
			regs[2] = ($urandom_range(0, 3) == 0) ? 48'($urandom) :
				48'($urandom_range(1 << 22, 1 << 26));
			regs[3] = 48'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20));
			regs[4] = ($urandom_range(0, 3) == 0) ? {16'($urandom), 32'($urandom)} :
				48'($urandom_range(1, 1000000)) << 16;
			regs[5] = ($urandom_range(0, 3) == 0) ? 48'($urandom) :
				48'($urandom_range(500, 3000)) << 16;
			regs[6] = ($urandom_range(0, 3) == 0) ? 48'($urandom) :
				48'($urandom_range(1 << 23, 1 << 25));
			load_regs(regs);
			quiet = (ph == 3) || (ph == 7);
			for (int n = 0; n < 130; n++)
				send_count(rand_count(regs[0]));
			drain();
		end

		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
